// ===== hw/rtl/nm2d_pkg.sv =====
// Package for the two-dimensional simplex minimiser.
// Holds the shared types and constants; no dependencies.
package nm2d_pkg;

    // Result kinds.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_FINAL   = 1'b1;

    // Input operations.
    localparam logic OP_START = 1'b0;
    localparam logic OP_COST  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_INITIAL_STEP   = 2'd0;
    localparam logic [1:0] REG_TOLERANCE      = 2'd1;
    localparam logic [1:0] REG_MAX_ITERATIONS = 2'd2;

    // Source of the offered point.
    localparam logic [2:0] SRC_VERTEX = 3'd0;
    localparam logic [2:0] SRC_REFL   = 3'd1;
    localparam logic [2:0] SRC_TRIAL  = 3'd2;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_START,       // load simplex from start point
        CMD_STORE_INIT,  // store cost of vertex given by index
        CMD_BEGIN,       // order vertices, centroid, reflected point
        CMD_STORE_REFL,  // store reflected cost
        CMD_EXPAND,      // compute expansion point
        CMD_CONTRACT,    // compute contraction point
        CMD_KEEP_TRIAL,  // replace worst with trial point
        CMD_KEEP_REFL,   // replace worst with reflected point
        CMD_SHRINK,      // shrink non-best vertices toward best
        CMD_STORE_SHR,   // store cost of shrunk vertex
        CMD_SPREAD,      // convergence sums, one vertex a step
        CMD_INC_ITER     // advance iteration count
    } nm2d_cmd_t;

    // Controller to datapath.
    typedef struct packed {
        nm2d_cmd_t  cmd;
        logic [1:0] idx;
    } nm2d_ctrl_t;

    // Datapath to controller.
    typedef struct packed {
        logic       refl_le_best;  // pending cost at or below best
        logic       cost_lt_worst; // pending cost below worst
        logic       cost_lt_refl;  // pending cost below reflected cost
        logic       converged;
        logic       limit_hit;     // count reached limit
        logic [1:0] best_idx;      // best of the current costs
        logic [1:0] anchor_idx;    // best vertex fixed when the iteration began
    } nm2d_stat_t;

endpackage

// ===== hw/rtl/nm2d_stream_if.sv =====
// Valid/ready channel interfaces for the simplex minimiser.
// Depends on nothing.
interface nm2d_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] cost;
    modport source (output valid, op, start_x, start_y, cost, input ready);
    modport sink (input valid, op, start_x, start_y, cost, output ready);
endinterface

interface nm2d_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] best_cost;
    logic [15:0] iterations_done;
    modport source (output valid, kind, point_x, point_y, best_cost, iterations_done,
                    input ready);
    modport sink (input valid, kind, point_x, point_y, best_cost, iterations_done,
                  output ready);
endinterface

// ===== hw/rtl/nm2d_datapath.sv =====
// Datapath of the simplex minimiser: vertex store, trial points and convergence sums.
// Depends on nm2d_pkg.
module nm2d_datapath
    import nm2d_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  nm2d_ctrl_t  ctrl,
    output nm2d_stat_t  stat,
    input  logic [31:0] in_x,
    input  logic [31:0] in_y,
    input  logic [31:0] in_cost,
    input  logic [30:0] initial_step,
    input  logic [30:0] tolerance,
    input  logic [15:0] max_iterations,
    output logic [31:0] vx_out,
    output logic [31:0] vy_out,
    output logic [31:0] vc_out,
    output logic [31:0] refl_x_out,
    output logic [31:0] refl_y_out,
    output logic [31:0] trial_x_out,
    output logic [31:0] trial_y_out,
    output logic [15:0] iter_out
);
    localparam int CW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam logic signed [35:0] CMAX = 36'sd1 <<< (CW - 1);
    localparam logic signed [35:0] SMAX = CMAX - 36'sd1;
    localparam logic signed [35:0] SMIN = -CMAX;

    // Saturate a wide value to the coordinate range.
    function automatic logic [31:0] sat36(input logic signed [35:0] v);
        logic signed [35:0] r;
        begin
            r = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
            sat36 = r[31:0];
        end
    endfunction

    function automatic logic signed [35:0] sx(input logic [31:0] v);
        sx = {{4{v[31]}}, v};
    endfunction

    // Floor halving is an arithmetic shift.
    function automatic logic signed [35:0] hf(input logic signed [35:0] v);
        hf = v >>> 1;
    endfunction

    logic [31:0] vx_reg [3];
    logic [31:0] vy_reg [3];
    logic [31:0] vc_reg [3];
    logic [31:0] cx_reg, cy_reg;
    logic [31:0] rx_reg, ry_reg, rc_reg;
    logic [31:0] tx_reg, ty_reg;
    logic [1:0]  worst_reg, best_reg;
    logic [15:0] iter_reg;
    logic signed [35:0] spread_reg;
    logic [63:0] dist_reg;
    logic [1:0]  sel;

    // Current worst/best search over the stored costs.
    logic [1:0] w_c, b_c;
    always_comb
    begin
        w_c = 2'd0;
        b_c = 2'd0;
        for (int i = 1; i < 3; i++)
        begin
            if ($signed(vc_reg[i]) > $signed(vc_reg[w_c])) w_c = 2'(i);
            if ($signed(vc_reg[i]) < $signed(vc_reg[b_c])) b_c = 2'(i);
        end
    end

    // Centroid of the two non-worst vertices.
    logic [1:0] o1, o2;
    logic signed [35:0] cxn, cyn;
    always_comb
    begin
        o1 = (w_c == 2'd0) ? 2'd1 : ((w_c == 2'd1) ? 2'd2 : 2'd0);
        o2 = (w_c == 2'd0) ? 2'd2 : ((w_c == 2'd1) ? 2'd0 : 2'd1);
        cxn = hf(sx(vx_reg[o1]) + sx(vx_reg[o2]));
        cyn = hf(sx(vy_reg[o1]) + sx(vy_reg[o2]));
    end

    // Differences from the stored worst vertex.
    logic signed [35:0] dxw, dyw;
    assign dxw = sx(cx_reg) - sx(vx_reg[worst_reg]);
    assign dyw = sx(cy_reg) - sx(vy_reg[worst_reg]);

    // One convergence step for vertex sel.
    logic signed [35:0] ddx, ddy;
    logic [35:0] adx, ady;
    logic [63:0] sqx, sqy, sum1, sum2;
    logic [64:0] add1, add2;
    always_comb
    begin
        ddx = sx(cx_reg) - sx(vx_reg[sel]);
        ddy = sx(cy_reg) - sx(vy_reg[sel]);
        adx = ddx[35] ? 36'(-ddx) : 36'(ddx);
        ady = ddy[35] ? 36'(-ddy) : 36'(ddy);
        sqx = (adx[35:32] != 4'd0) ? (64'hFFFF_FFFF_FFFF_FFFF >> 16)
                                   : ((64'(adx[31:0]) * 64'(adx[31:0])) >> 16);
        sqy = (ady[35:32] != 4'd0) ? (64'hFFFF_FFFF_FFFF_FFFF >> 16)
                                   : ((64'(ady[31:0]) * 64'(ady[31:0])) >> 16);
        add1 = {1'b0, dist_reg} + {1'b0, sqx};
        sum1 = add1[64] ? 64'hFFFF_FFFF_FFFF_FFFF : add1[63:0];
        add2 = {1'b0, sum1} + {1'b0, sqy};
        sum2 = add2[64] ? 64'hFFFF_FFFF_FFFF_FFFF : add2[63:0];
    end

    assign sel = ctrl.idx;

    // Register updates per command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
                vc_reg[i] <= '0;
            end
            cx_reg <= '0; cy_reg <= '0;
            rx_reg <= '0; ry_reg <= '0; rc_reg <= '0;
            tx_reg <= '0; ty_reg <= '0;
            worst_reg <= '0; best_reg <= '0;
            iter_reg <= '0;
            spread_reg <= '0;
            dist_reg <= '0;
        end
        else
        begin
            case (ctrl.cmd)
                CMD_START:
                begin
                    vx_reg[0] <= sat36(sx(in_x));
                    vy_reg[0] <= sat36(sx(in_y));
                    vx_reg[1] <= sat36(sx(sat36(sx(in_x))) + 36'(initial_step));
                    vy_reg[1] <= sat36(sx(sat36(sx(in_y))) - 36'(initial_step));
                    vx_reg[2] <= sat36(sx(sat36(sx(in_x))) - 36'(initial_step));
                    vy_reg[2] <= sat36(sx(sat36(sx(in_y))) - 36'(initial_step));
                    for (int i = 0; i < 3; i++) vc_reg[i] <= '0;
                    iter_reg <= '0;
                end
                CMD_STORE_INIT, CMD_STORE_SHR:
                    vc_reg[sel] <= in_cost;
                CMD_BEGIN:
                begin
                    worst_reg <= w_c;
                    best_reg  <= b_c;
                    cx_reg <= cxn[31:0];
                    cy_reg <= cyn[31:0];
                    rx_reg <= sat36(cxn + (cxn - sx(vx_reg[w_c])));
                    ry_reg <= sat36(cyn + (cyn - sx(vy_reg[w_c])));
                end
                CMD_STORE_REFL:
                    rc_reg <= in_cost;
                CMD_EXPAND:
                begin
                    tx_reg <= sat36(sx(cx_reg) + (dxw <<< 1));
                    ty_reg <= sat36(sx(cy_reg) + (dyw <<< 1));
                end
                CMD_CONTRACT:
                begin
                    tx_reg <= sat36(sx(cx_reg) - hf(dxw));
                    ty_reg <= sat36(sx(cy_reg) - hf(dyw));
                end
                CMD_KEEP_TRIAL:
                begin
                    vx_reg[worst_reg] <= tx_reg;
                    vy_reg[worst_reg] <= ty_reg;
                    vc_reg[worst_reg] <= in_cost;
                end
                CMD_KEEP_REFL:
                begin
                    vx_reg[worst_reg] <= rx_reg;
                    vy_reg[worst_reg] <= ry_reg;
                    vc_reg[worst_reg] <= rc_reg;
                end
                CMD_SHRINK:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (2'(i) != best_reg)
                        begin
                            vx_reg[i] <= sat36(sx(vx_reg[best_reg]) -
                                hf(sx(vx_reg[best_reg]) - sx(vx_reg[i])));
                            vy_reg[i] <= sat36(sx(vy_reg[best_reg]) -
                                hf(sx(vy_reg[best_reg]) - sx(vy_reg[i])));
                        end
                    end
                end
                CMD_SPREAD:
                begin
                    if (sel == 2'd0)
                    begin
                        spread_reg <= sx(vc_reg[0]) - sx(vc_reg[b_c]);
                        dist_reg   <= 64'(sqx) + 64'(sqy);
                    end
                    else
                    begin
                        spread_reg <= spread_reg + sx(vc_reg[sel]) - sx(vc_reg[b_c]);
                        dist_reg   <= sum2;
                    end
                end
                CMD_INC_ITER:
                    iter_reg <= iter_reg + 16'd1;
                default:
                begin
                end
            endcase
        end
    end

    // The mean of the distance sum is below the tolerance exactly when the sum
    // is below three times the tolerance, so no divider is needed.
    logic [32:0] tol3;
    assign tol3 = {1'b0, tolerance, 1'b0} + {2'b0, tolerance};

    // Status back to the controller.
    always_comb
    begin
        stat.refl_le_best  = $signed(in_cost) <= $signed(vc_reg[best_reg]);
        stat.cost_lt_worst = $signed(in_cost) < $signed(vc_reg[worst_reg]);
        stat.cost_lt_refl  = $signed(in_cost) < $signed(rc_reg);
        stat.converged     = (spread_reg < $signed({5'd0, tolerance})) &&
                             (dist_reg < 64'(tol3));
        stat.limit_hit     = iter_reg >= max_iterations;
        stat.best_idx      = b_c;
        stat.anchor_idx    = best_reg;
    end

    assign vx_out      = vx_reg[sel];
    assign vy_out      = vy_reg[sel];
    assign vc_out      = vc_reg[sel];
    assign refl_x_out  = rx_reg;
    assign refl_y_out  = ry_reg;
    assign trial_x_out = tx_reg;
    assign trial_y_out = ty_reg;
    assign iter_out    = iter_reg;
endmodule

// ===== hw/rtl/nm2d_ctrl.sv =====
// Controller of the simplex minimiser: phase sequencing and result launch.
// Depends on nm2d_pkg.
module nm2d_ctrl
    import nm2d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_op,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_kind,
    output logic [2:0] out_src,   // vertex, reflected or trial point
    output nm2d_ctrl_t ctrl,
    input  nm2d_stat_t stat
);
    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001, // waiting for start
        S_WAIT    = 11'b00000000010, // waiting for a cost reply
        S_BEGIN   = 11'b00000000100,
        S_SPREAD  = 11'b00000001000,
        S_CHECK   = 11'b00000010000,
        S_SHRINK  = 11'b00000100000,
        S_NEXTSH  = 11'b00001000000,
        S_EMIT    = 11'b00010000000,
        S_FINAL   = 11'b00100000000,
        S_LIMIT   = 11'b01000000000,
        S_PAUSE   = 11'b10000000000
    } state_t;

    typedef enum logic [2:0] {
        PH_INIT, PH_REFL, PH_EXP, PH_CON, PH_SHR, PH_NONE
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [1:0] idx_reg, idx_next;
    logic       kind_reg, kind_next;
    logic [2:0] src_reg, src_next;
    logic       acc;

    assign in_ready = (state_reg == S_IDLE) || (state_reg == S_WAIT);
    assign acc      = in_valid && in_ready;
    assign out_valid = (state_reg == S_EMIT);
    assign out_kind  = kind_reg;
    assign out_src   = src_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        kind_next  = kind_reg;
        src_next   = src_reg;
        ctrl.cmd   = CMD_NONE;
        ctrl.idx   = idx_reg;
        case (state_reg)
            S_IDLE, S_WAIT:
            begin
                if (acc && in_op == OP_START)
                begin
                    ctrl.cmd   = CMD_START;
                    phase_next = PH_INIT;
                    idx_next   = 2'd0;
                    kind_next  = KIND_REQUEST;
                    src_next   = SRC_VERTEX;
                    state_next = S_EMIT;
                end
                else if (acc && state_reg == S_WAIT)
                begin
                    case (phase_reg)
                        PH_INIT:
                        begin
                            ctrl.cmd = CMD_STORE_INIT;
                            if (idx_reg == 2'd2)
                                state_next = S_LIMIT;
                            else
                            begin
                                idx_next   = idx_reg + 2'd1;
                                src_next   = SRC_VERTEX;
                                state_next = S_EMIT;
                            end
                        end
                        PH_REFL:
                        begin
                            ctrl.cmd = CMD_STORE_REFL;
                            if (stat.refl_le_best)
                            begin
                                phase_next = PH_EXP;
                                state_next = S_PAUSE;
                            end
                            else if (stat.cost_lt_worst)
                                state_next = S_PAUSE;
                            else
                            begin
                                phase_next = PH_CON;
                                state_next = S_PAUSE;
                            end
                        end
                        PH_EXP:
                        begin
                            ctrl.cmd = stat.cost_lt_refl ? CMD_KEEP_TRIAL : CMD_KEEP_REFL;
                            idx_next   = 2'd0;
                            state_next = S_SPREAD;
                        end
                        PH_CON:
                        begin
                            if (stat.cost_lt_worst)
                            begin
                                ctrl.cmd   = CMD_KEEP_TRIAL;
                                idx_next   = 2'd0;
                                state_next = S_SPREAD;
                            end
                            else
                            begin
                                ctrl.cmd   = CMD_SHRINK;
                                idx_next   = 2'd0;
                                state_next = S_NEXTSH;
                            end
                        end
                        PH_SHR:
                        begin
                            ctrl.cmd   = CMD_STORE_SHR;
                            idx_next   = idx_reg + 2'd1;
                            state_next = S_NEXTSH;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            // Entered after a reflected cost is stored: act on the stored cost.
            S_PAUSE:
            begin
                kind_next = KIND_REQUEST;
                src_next  = SRC_TRIAL;
                case (phase_reg)
                    PH_EXP:
                    begin
                        ctrl.cmd   = CMD_EXPAND;
                        state_next = S_EMIT;
                    end
                    PH_CON:
                    begin
                        ctrl.cmd   = CMD_CONTRACT;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        ctrl.cmd   = CMD_KEEP_REFL;
                        idx_next   = 2'd0;
                        state_next = S_SPREAD;
                    end
                endcase
            end
            // Find the next vertex to request, skipping the best vertex that the
            // iteration started with.
            S_NEXTSH:
            begin
                if (idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    state_next = S_SPREAD;
                end
                else if (idx_reg == stat.anchor_idx)
                    idx_next = idx_reg + 2'd1;
                else
                begin
                    phase_next = PH_SHR;
                    kind_next  = KIND_REQUEST;
                    src_next   = SRC_VERTEX;
                    state_next = S_EMIT;
                end
            end
            // Convergence sums, one vertex per cycle.
            S_SPREAD:
            begin
                ctrl.cmd = CMD_SPREAD;
                if (idx_reg == 2'd2)
                    state_next = S_CHECK;
                else
                    idx_next = idx_reg + 2'd1;
            end
            S_CHECK:
            begin
                if (stat.converged)
                    state_next = S_FINAL;
                else
                begin
                    ctrl.cmd   = CMD_INC_ITER;
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:
                state_next = stat.limit_hit ? S_FINAL : S_BEGIN;
            S_BEGIN:
            begin
                ctrl.cmd   = CMD_BEGIN;
                phase_next = PH_REFL;
                kind_next  = KIND_REQUEST;
                src_next   = SRC_REFL;
                state_next = S_EMIT;
            end
            S_FINAL:
            begin
                idx_next   = stat.best_idx;
                phase_next = PH_NONE;
                kind_next  = KIND_FINAL;
                src_next   = SRC_VERTEX;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_ready)
                    state_next = (kind_reg == KIND_FINAL) ? S_IDLE : S_WAIT;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_NONE;
            idx_reg   <= '0;
            kind_reg  <= KIND_REQUEST;
            src_reg   <= SRC_VERTEX;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            kind_reg  <= kind_next;
            src_reg   <= src_next;
        end
    end

    // A reply is only taken while waiting or idle.
    a_ready_states: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE || state_reg == S_WAIT))
        else $error("ready outside waiting states");
    // A start always launches a request next.
    a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && in_op == OP_START) |=> (state_reg == S_EMIT))
        else $error("start did not launch request");
    // No input is taken while a result is offered.
    a_no_take_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
endmodule

// ===== hw/rtl/nelder_mead_2d_sequencer.sv =====
// Top level of the two-dimensional simplex minimiser with an external cost oracle.
// Depends on nm2d_pkg, the channel interfaces, nm2d_ctrl and nm2d_datapath.
// Each input transfer (a start point or a cost reply) produces one result transfer:
// either the next point whose cost is wanted or the final best point. After a
// start the request is offered in the next cycle. The longest path after a
// cost reply follows the last shrink reply, which skips the best vertex,
// walks the three vertices through the convergence sums one per cycle, then
// the convergence check, the limit check and the next reflection.
// The block takes a new input only while it waits for a reply or is idle.
module nelder_mead_2d_sequencer
    import nm2d_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    nm2d_in_if.sink     in_ch,
    nm2d_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    logic [30:0] initial_step_reg, tolerance_reg;
    logic [15:0] max_iter_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_step_reg <= 31'd655360;
            tolerance_reg    <= 31'd328;
            max_iter_reg     <= 16'd5000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INITIAL_STEP:   initial_step_reg <= cfg_data;
                REG_TOLERANCE:      tolerance_reg    <= cfg_data;
                REG_MAX_ITERATIONS: max_iter_reg     <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    nm2d_ctrl_t ctrl;
    nm2d_stat_t stat;
    logic       kind;
    logic [2:0] src;
    logic [31:0] vx, vy, vc, rx, ry, tx, ty;
    logic [15:0] iter;

    nm2d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_op     (in_ch.op),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_kind  (kind),
        .out_src   (src),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    nm2d_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .in_x           (in_ch.start_x),
        .in_y           (in_ch.start_y),
        .in_cost        (in_ch.cost),
        .initial_step   (initial_step_reg),
        .tolerance      (tolerance_reg),
        .max_iterations (max_iter_reg),
        .vx_out         (vx),
        .vy_out         (vy),
        .vc_out         (vc),
        .refl_x_out     (rx),
        .refl_y_out     (ry),
        .trial_x_out    (tx),
        .trial_y_out    (ty),
        .iter_out       (iter)
    );

    // Result payload, held steady by the datapath while offered.
    always_comb
    begin
        out_ch.kind = kind;
        case (src)
            SRC_REFL:
            begin
                out_ch.point_x = rx;
                out_ch.point_y = ry;
            end
            SRC_TRIAL:
            begin
                out_ch.point_x = tx;
                out_ch.point_y = ty;
            end
            default:
            begin
                out_ch.point_x = vx;
                out_ch.point_y = vy;
            end
        endcase
        out_ch.best_cost       = (kind == KIND_FINAL) ? vc : 32'd0;
        out_ch.iterations_done = (kind == KIND_FINAL) ? iter : 16'd0;
    end
endmodule
